/* sv/oaids_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_pkg
// Shared types and field widths of the ordered array with insert, delete and
// search.
// ----------------------------------------------------------------------------
package oaids_pkg;

    // number of entries, tied to the position and count field widths
    localparam int DEPTH    = 16;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int FILL_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic compare;
        logic valid;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* sv/oaids_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_cell
// One array entry: loads a new word, takes a neighbor's word on a shift and
// registers a match flag against the search key.
// ----------------------------------------------------------------------------
module oaids_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                       i_clk,
    input  oaids_pkg::t_cell_ctl      i_ctl,
    input  wire  [DATA_WIDTH-1:0]     i_left,
    input  wire  [DATA_WIDTH-1:0]     i_right,
    input  wire  [DATA_WIDTH-1:0]     i_load_data,
    input  wire  [DATA_WIDTH-1:0]     i_key,
    output logic [DATA_WIDTH-1:0]     o_data,
    output logic                      o_hit
);
    import oaids_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.take_left) begin
            r_data <= i_left;
        end else if (i_ctl.take_right) begin
            r_data <= i_right;
        end else begin
            r_data <= r_data;
        end
        if (i_ctl.compare) begin
            r_hit <= i_ctl.valid && (r_data == i_key);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

/* sv/ordered_array_insert_delete_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search
// Positional array of signed words with a fill count: insert at a position,
// delete at a position, linear search for a value.
// ----------------------------------------------------------------------------
// Each entry lives in its own cell; insert loads the word at the position and
// delete removes it, the cells above shifting one place in the accept cycle, so
// those commands (and rejected ones) finish in the accept cycle and the next
// word can follow in the next cycle. A search compares all cells in the accept
// cycle and then scans the registered match flags eight per cycle, stopping at
// the first group with a hit or at the last group. The result sits in an output
// register, and a new word is taken only when that register is empty or is
// being read in the same cycle, so a stalled receiver stalls the input. No
// clearing pass after reset; entries at or above the fill count are never read.
module ordered_array_insert_delete_search #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [oaids_pkg::CMD_W-1:0]          i_cmd,
    input  wire  [oaids_pkg::POS_W-1:0]          i_position,
    input  wire  signed [oaids_pkg::VAL_W-1:0]   i_value,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [oaids_pkg::STATUS_W-1:0]       o_status,
    output logic [oaids_pkg::FOUND_W-1:0]        o_found_position,
    output logic [oaids_pkg::FILL_W-1:0]         o_fill_count
);
    import oaids_pkg::*;

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int GW     = 8;
    localparam int GIX_W  = $clog2(GW);
    localparam int NGRP   = (DEPTH + GW - 1) / GW;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int HIT_W  = NGRP * GW;
    localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [GRP_W-1:0]     r_grp;
    logic                 r_out_valid;
    t_status              r_status;
    logic [FOUND_W-1:0]   r_found;
    logic [FILL_W-1:0]    r_fill;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 is_full;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 srch;
    t_status              imm_status;
    logic [CW-1:0]        n_count;
    logic [DATA_WIDTH-1:0] key;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [HIT_W-1:0]      w_hit;
    logic [GW-1:0]         grp_bits;
    logic                  g_any;
    logic [GIX_W-1:0]      g_idx;
    logic                  last;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    assign pos_ext = CMP_W'(i_position);
    assign cnt_ext = CMP_W'(r_count);
    assign is_full = (r_count == CW'(DEPTH));
    assign key     = DATA_WIDTH'($unsigned(i_value));

    assign ins_ok = accept && (i_cmd == CMD_INSERT) && !is_full && (pos_ext <= cnt_ext);
    assign del_ok = accept && (i_cmd == CMD_DELETE) && (pos_ext < cnt_ext);
    assign srch   = accept && (i_cmd == CMD_SEARCH);

    always_comb begin
        imm_status = ST_BAD;
        n_count    = r_count;
        if (i_cmd == CMD_INSERT) begin
            if (is_full) begin
                imm_status = ST_FULL;
            end else if (pos_ext <= cnt_ext) begin
                imm_status = ST_OK;
                n_count    = CW'(r_count + 1'b1);
            end
        end else if (i_cmd == CMD_DELETE) begin
            if (pos_ext < cnt_ext) begin
                imm_status = ST_OK;
                n_count    = CW'(r_count - 1'b1);
            end
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl             ctl;
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        assign ctl.load       = ins_ok && (CMP_W'(g) == pos_ext);
        assign ctl.take_left  = ins_ok && (CMP_W'(g) > pos_ext);
        assign ctl.take_right = del_ok && (CMP_W'(g) >= pos_ext);
        assign ctl.compare    = srch;
        assign ctl.valid      = (CMP_W'(g) < cnt_ext);

        if (g == 0) begin : g_first
            assign left = w_data[g];
        end else begin : g_mid_l
            assign left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = w_data[g];
        end else begin : g_mid_r
            assign right = w_data[g+1];
        end

        oaids_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_left      (left),
            .i_right     (right),
            .i_load_data (key),
            .i_key       (key),
            .o_data      (w_data[g]),
            .o_hit       (w_hit[g])
        );
    end

    if (HIT_W > DEPTH) begin : g_pad
        assign w_hit[HIT_W-1:DEPTH] = '0;
    end

    // group scan of match flags
    assign grp_bits = w_hit[r_grp*GW +: GW];
    assign last     = (r_grp == GRP_W'(NGRP - 1));

    always_comb begin
        g_any = 1'b0;
        g_idx = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (grp_bits[i]) begin
                g_any = 1'b1;
                g_idx = GIX_W'(i);
            end
        end
    end

    // a result enters the output register
    assign out_load = ((r_state == S_IDLE) && accept && !srch)
                   || ((r_state == S_SCAN) && (g_any || last) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_grp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= n_count;
                        if (srch) begin
                            r_state <= S_SCAN;
                            r_grp   <= '0;
                        end else begin
                            r_status    <= imm_status;
                            r_found     <= '0;
                            r_fill      <= FILL_W'(n_count);
                        end
                    end
                end
                S_SCAN: begin
                    if (g_any || last) begin
                        if (out_free) begin
                            r_status    <= g_any ? ST_OK : ST_MISS;
                            r_found     <= g_any ? FOUND_W'({r_grp, g_idx}) : '0;
                            r_fill      <= FILL_W'(r_count);
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_grp <= GRP_W'(r_grp + 1'b1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_fill_count     = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_found_position == '0))
        else $error("found position set on a failed word");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow the fill count");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("fill count changed during search");

endmodule
`default_nettype wire

/* tb/oaids_array_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaids_array_checker
// Watches both channels of the ordered array, keeps a shadow copy of the
// entries and the fill count, predicts the result of every accepted word and
// compares each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module oaids_array_checker #(
    parameter int DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_word_valid,
    input  wire                              i_word_ready,
    input  wire  [oaids_pkg::CMD_W-1:0]      i_cmd,
    input  wire  [oaids_pkg::POS_W-1:0]      i_position,
    input  wire  [oaids_pkg::VAL_W-1:0]      i_value,
    input  wire                              i_res_valid,
    input  wire                              i_res_ready,
    input  wire  [oaids_pkg::STATUS_W-1:0]   i_status,
    input  wire  [oaids_pkg::FOUND_W-1:0]    i_found_position,
    input  wire  [oaids_pkg::FILL_W-1:0]     i_fill_count,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_search_hits,
    output int                               o_rejects,
    output int                               o_full_rejects
);
    import oaids_pkg::*;

    typedef struct packed {
        t_status               status;
        logic [FOUND_W-1:0]    found;
        logic [FILL_W-1:0]     fill;
    } t_array_result;

    logic [VAL_W-1:0] array_words [DEPTH];
    int               array_fill;
    t_array_result    expected_results [$];
    int               errors;
    int               checked;
    int               search_hits;
    int               rejects;
    int               full_rejects;

    function automatic t_array_result apply_array_op(input logic [CMD_W-1:0] cmd,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] val);
        t_array_result res;
        int            k;
        res.status = ST_OK;
        res.found  = '0;
        case (cmd)
            CMD_INSERT: begin
                if (array_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > array_fill) begin
                    res.status = ST_BAD;
                end else begin
                    for (k = array_fill; k > int'(pos); k--)
                        array_words[k] = array_words[k-1];
                    array_words[pos] = val;
                    array_fill++;
                end
            end
            CMD_DELETE: begin
                if (int'(pos) >= array_fill) begin
                    res.status = ST_BAD;
                end else begin
                    for (k = int'(pos); k < array_fill - 1; k++)
                        array_words[k] = array_words[k+1];
                    array_fill--;
                end
            end
            CMD_SEARCH: begin
                // scan downward so the lowest match wins
                res.status = ST_MISS;
                for (k = array_fill - 1; k >= 0; k--) begin
                    if (array_words[k] == val) begin
                        res.status = ST_OK;
                        res.found  = FOUND_W'(k);
                    end
                end
            end
            default: begin
                res.status = ST_BAD;
            end
        endcase
        res.fill = FILL_W'(array_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_array_result want;
        t_array_result pred;
        if (!i_rst_n) begin
            array_fill = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: status %0d found %0d fill %0d",
                             $time, i_status, i_found_position, i_fill_count);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (i_status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_found_position !== want.found) begin
                        errors++;
                        $display("%0t: found_position expected %0d actual %0d",
                                 $time, want.found, i_found_position);
                    end
                    if (i_fill_count !== want.fill) begin
                        errors++;
                        $display("%0t: fill_count expected %0d actual %0d",
                                 $time, want.fill, i_fill_count);
                    end
                end
            end
            if (i_word_valid && i_word_ready) begin
                pred = apply_array_op(i_cmd, i_position, i_value);
                expected_results.push_back(pred);
                if (i_cmd == CMD_SEARCH && pred.status == ST_OK)
                    search_hits++;
                if (pred.status == ST_BAD || pred.status == ST_FULL)
                    rejects++;
                if (pred.status == ST_FULL)
                    full_rejects++;
            end
        end
        o_errors       <= errors;
        o_pending      <= expected_results.size();
        o_checked      <= checked;
        o_search_hits  <= search_hits;
        o_rejects      <= rejects;
        o_full_rejects <= full_rejects;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ordered array with a directed opening (empty, full, ends, bad
// positions, unused command, extreme values) and then random insert, delete
// and search words with random gaps and back pressure; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import oaids_pkg::*;

    localparam int               RANDOM_WORDS = 1700;
    localparam int               HOLD_CYCLES = 80;
    localparam int               STALL_LIMIT = 2000;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                word_valid;
    logic                word_ready;
    logic [CMD_W-1:0]    word_cmd;
    logic [POS_W-1:0]    word_position;
    logic [VAL_W-1:0]    word_value;
    logic                res_valid;
    logic                res_ready;
    logic [STATUS_W-1:0] res_status;
    logic [FOUND_W-1:0]  res_found;
    logic [FILL_W-1:0]   res_fill;

    int errors;
    int pending;
    int checked;
    int search_hits;
    int rejects;
    int full_rejects;

    int   words_sent;
    int   fill_guess;
    int   idle_cycles;
    bit   word_quiet;
    bit   hold_request;
    bit   hold_done;
    logic [VAL_W-1:0] value_pool [8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_array_insert_delete_search #(
        .DATA_WIDTH (VAL_W)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (word_valid),
        .o_ready          (word_ready),
        .i_cmd            (word_cmd),
        .i_position       (word_position),
        .i_value          (word_value),
        .o_valid          (res_valid),
        .i_ready          (res_ready),
        .o_status         (res_status),
        .o_found_position (res_found),
        .o_fill_count     (res_fill)
    );

    oaids_array_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_word_valid     (word_valid),
        .i_word_ready     (word_ready),
        .i_cmd            (word_cmd),
        .i_position       (word_position),
        .i_value          (word_value),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_status         (res_status),
        .i_found_position (res_found),
        .i_fill_count     (res_fill),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_search_hits    (search_hits),
        .o_rejects        (rejects),
        .o_full_rejects   (full_rejects)
    );

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        int gap;
        gap = word_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid    <= 1'b1;
        word_cmd      <= cmd;
        word_position <= pos;
        word_value    <= val;
        @(posedge clk);
        while (!word_ready) @(posedge clk);
        words_sent++;
        // rough fill tracking, only to steer positions into range
        if (cmd == CMD_INSERT && fill_guess < DEPTH && int'(pos) <= fill_guess)
            fill_guess++;
        else if (cmd == CMD_DELETE && int'(pos) < fill_guess)
            fill_guess--;
    endtask

    // result side: random stalls, one long hold on request
    initial begin : result_side
        int stall;
        int taken;
        bit res_quiet;
        taken     = 0;
        res_quiet = 1'b0;
        res_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request && !hold_done) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                stall = res_quiet ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            taken++;
            if (taken % 50 == 0)
                res_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk) begin
        if ((word_valid && word_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : word_side
        int               n;
        int               k;
        int               r;
        int               insert_weight;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        rst_n         <= 1'b0;
        word_valid    <= 1'b0;
        word_cmd      <= CMD_INSERT;
        word_position <= '0;
        word_value    <= '0;
        words_sent    = 0;
        fill_guess    = 0;
        word_quiet    = 1'b0;
        hold_request  = 1'b0;
        insert_weight = 35;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = 32'h0000_0000;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty array, bad positions, unused command
        send_word(CMD_SEARCH, 5'd0, 32'h0000_0000);
        send_word(CMD_DELETE, 5'd0, 32'h0000_0000);
        send_word(CMD_INSERT, 5'd1, 32'h0000_0001);
        send_word(CMD_UNUSED, 5'd31, 32'hffff_ffff);
        // extremes at front and end
        send_word(CMD_INSERT, 5'd0, 32'h8000_0000);
        send_word(CMD_INSERT, 5'd1, 32'h7fff_ffff);
        send_word(CMD_INSERT, 5'd0, 32'hffff_ffff);
        send_word(CMD_SEARCH, 5'd0, 32'h7fff_ffff);
        send_word(CMD_SEARCH, 5'd0, 32'h0000_3039);
        send_word(CMD_DELETE, 5'd3, 32'h0000_0000);
        // fill up with duplicates, then overflow
        for (k = 0; k < 13; k++)
            send_word(CMD_INSERT, POS_W'(3 + k), k[0] ? 32'h8000_0000 : VAL_W'(k));
        send_word(CMD_INSERT, 5'd31, 32'h1234_5678);
        send_word(CMD_SEARCH, 5'd0, 32'h8000_0000);
        send_word(CMD_SEARCH, 5'd0, 32'h0000_000c);
        send_word(CMD_DELETE, 5'd15, 32'h0000_0000);
        send_word(CMD_DELETE, 5'd0, 32'h0000_0000);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                word_quiet = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0:       insert_weight = 15;
                    1:       insert_weight = 35;
                    default: insert_weight = 55;
                endcase
            end
            if (n == RANDOM_WORDS / 2)
                hold_request = 1'b1;
            r = $urandom_range(0, 99);
            if (r < insert_weight)
                cmd = CMD_INSERT;
            else if (r < 70)
                cmd = CMD_DELETE;
            else if (r < 97)
                cmd = CMD_SEARCH;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 9) == 0 || cmd == CMD_SEARCH || cmd == CMD_UNUSED)
                pos = POS_W'($urandom_range(0, 31));
            else if (cmd == CMD_INSERT)
                pos = POS_W'($urandom_range(0, fill_guess));
            else
                pos = (fill_guess == 0) ? '0 : POS_W'($urandom_range(0, fill_guess - 1));
            val = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                                              : value_pool[3'($urandom_range(0, 7))];
            send_word(cmd, pos, val);
        end
        word_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run covered %0d words and %0d checked results", words_sent, checked);
        $display("search hits %0d, rejected words %0d, inserts into a full array %0d",
                 search_hits, rejects, full_rejects);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/oaids_pkg.sv
sv/oaids_cell.sv
sv/ordered_array_insert_delete_search.sv
tb/oaids_array_checker.sv
tb/testbench.sv
